// ===== src/pwm_motif_scan_both_strands_unit_macros.svh =====
// Assertion macros for the motif scanner.
`ifndef PWM_MOTIF_SCAN_BOTH_STRANDS_UNIT_MACROS_SVH
`define PWM_MOTIF_SCAN_BOTH_STRANDS_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define PMS_ASSERT(label, clk, rstn, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`else
`define PMS_ASSERT(label, clk, rstn, prop, msg)
`endif
`ifndef SYNTHESIS
`define PMS_ASSERT_NR(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define PMS_ASSERT_NR(label, clk, prop, msg)
`endif
`endif

// ===== src/pms_pkg.sv =====
// ----------------------------------------------------------------------------
// pms_pkg
// Shared constants and command types of the motif scanner.
// ----------------------------------------------------------------------------
`default_nettype none
package pms_pkg;
  localparam int MaxMotifLen = 32;
  localparam int WeightBits  = 16;
  localparam int ScoreBits   = 24;
  localparam int CfgThreshold = 0;
  localparam int CfgMotifLen  = 1;
  localparam logic CmdLoad = 1'b0;
  localparam logic CmdBase = 1'b1;

  // Controller to datapath commands.
  typedef struct packed {
    logic load_in;   // capture input transaction
    logic clr_acc;   // start a window sum; also commits a captured weight load
    logic acc_step;  // add one column on both strands
    logic fold;      // fold window sums into best score
    logic finish;    // on result hand-off, reset sequence state and advance index
  } pms_cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic is_base;
    logic is_last;
    logic have_win;  // enough bases for a window
    logic col_done;  // column counter reached window length
  } pms_sts_t;
endpackage
`default_nettype wire

// ===== src/pwm_motif_scan_both_strands_unit.sv =====
// ----------------------------------------------------------------------------
// pwm_motif_scan_both_strands_unit
// Position weight matrix scanner over both strands of a DNA stream.
// ----------------------------------------------------------------------------
// Usage: the slave channel carries weight loads (cmd 0) and bases (cmd 1).
// Transactions are taken one at a time; tready is high only while idle.
// A load passes through the decode state before tready returns, and so does
// a base before a full window. A base that completes a window passes through
// acceptance, decode, the column sweep that reads the weight memory on two
// read ports, forward and reverse, one column per cycle, a drain of the read
// pipeline and a fold of the sums into the best score. A base with tlast then
// offers one result on the master channel in the next cycle: sequence index,
// hit flag and best score, the score reading zero without a hit. The result
// stays valid until taken; while the receiver stalls no new transaction is
// accepted. Reset clears the window, counters and best score; the weight
// memory holds no reset value and must be loaded before scanning.
// Configuration writes (threshold, motif length) go through cfg_we_i; the
// user must issue them while the block is idle; the block does not enforce it.
// ----------------------------------------------------------------------------
`default_nettype none
module pwm_motif_scan_both_strands_unit #(
  parameter int MaxLen = pms_pkg::MaxMotifLen,
  parameter int WBits  = pms_pkg::WeightBits,
  parameter int SBits  = pms_pkg::ScoreBits
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic s_axis_tvalid,
  output logic s_axis_tready,
  // tdata: base[2:0], weight_column[7:3], weight_row[9:8], weight_value[25:10]
  input  wire logic [31:0] s_axis_tdata,
  input  wire logic s_axis_tlast,
  // tuser: cmd[0]
  input  wire logic s_axis_tuser,
  output logic m_axis_tvalid,
  input  wire logic m_axis_tready,
  // tdata: seq_index[31:0], hit[32], best_score[56:33]
  output logic [63:0] m_axis_tdata,
  input  wire logic cfg_we_i,
  input  wire logic cfg_idx_i,
  input  wire logic [23:0] cfg_data_i
);
  import pms_pkg::*;
  pms_cmd_t cmd;
  pms_sts_t sts;
  logic [31:0] idx;
  logic hit;
  logic signed [23:0] score;

  pms_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i(s_axis_tvalid), .in_ready_o(s_axis_tready),
    .out_valid_o(m_axis_tvalid), .out_ready_i(m_axis_tready),
    .cmd_o(cmd), .sts_i(sts)
  );

  pms_datapath #(.MaxLen(MaxLen), .WBits(WBits), .SBits(SBits)) u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .sts_o(sts),
    .in_cmd_i(s_axis_tuser), .in_base_i(s_axis_tdata[2:0]), .in_last_i(s_axis_tlast),
    .in_col_i(s_axis_tdata[7:3]), .in_row_i(s_axis_tdata[9:8]),
    .in_wval_i(s_axis_tdata[25:10]),
    .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .res_index_o(idx), .res_hit_o(hit), .res_score_o(score)
  );

  assign m_axis_tdata = {7'd0, score, hit, idx};
endmodule
`default_nettype wire

// ===== src/pms_datapath.sv =====
// ----------------------------------------------------------------------------
// pms_datapath
// Weight memory, base window, column accumulators and sequence state.
// ----------------------------------------------------------------------------
`default_nettype none
module pms_datapath #(
  parameter int MaxLen = 32,
  parameter int WBits  = 16,
  parameter int SBits  = 24
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire pms_pkg::pms_cmd_t cmd_i,
  output pms_pkg::pms_sts_t sts_o,
  input  wire logic in_cmd_i,
  input  wire logic [2:0] in_base_i,
  input  wire logic in_last_i,
  input  wire logic [4:0] in_col_i,
  input  wire logic [1:0] in_row_i,
  input  wire logic signed [15:0] in_wval_i,
  input  wire logic cfg_we_i,
  input  wire logic cfg_idx_i,
  input  wire logic [23:0] cfg_data_i,
  output logic [31:0] res_index_o,
  output logic res_hit_o,
  output logic signed [23:0] res_score_o
);
  import pms_pkg::*;
  localparam int CW = $clog2(MaxLen + 1);
  localparam int IW = (MaxLen > 1) ? $clog2(MaxLen) : 1;
  localparam int AW = IW + 2;
  localparam int ACCW = SBits + 8;
  localparam logic signed [SBits-1:0] SMin = {1'b1, {(SBits-1){1'b0}}};
  localparam logic signed [SBits-1:0] SMax = {1'b0, {(SBits-1){1'b1}}};
  localparam logic signed [WBits-1:0] WMax = {1'b0, {(WBits-1){1'b1}}};
  localparam logic signed [WBits-1:0] WMin = {1'b1, {(WBits-1){1'b0}}};

  // Configuration registers.
  logic signed [23:0] thr_q;
  logic [5:0] mlen_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= '0;
      mlen_q <= 6'd8;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == 1'(CfgThreshold)) thr_q <= cfg_data_i;
      else mlen_q <= cfg_data_i[5:0];
    end
  end

  // Effective window length.
  logic [CW-1:0] len;
  always_comb begin
    if (mlen_q == 6'd0) len = CW'(1);
    else if (32'(mlen_q) > MaxLen) len = CW'(MaxLen);
    else len = CW'(mlen_q);
  end

  // Captured input.
  logic cmd_q, last_q;
  logic [2:0] base_q;
  logic [4:0] col_q;
  logic [1:0] row_q;
  logic signed [15:0] wv_q;
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      cmd_q <= in_cmd_i; base_q <= in_base_i; last_q <= in_last_i;
      col_q <= in_col_i; row_q <= in_row_i; wv_q <= in_wval_i;
    end
  end

  // Saturate loaded weight.
  logic signed [WBits-1:0] wsat;
  always_comb begin
    if (32'(wv_q) > 32'(WMax)) wsat = WMax;
    else if (32'(wv_q) < 32'(WMin)) wsat = WMin;
    else wsat = WBits'(wv_q);
  end

  // Window shift line; newest at top.
  logic [2:0] win_q [MaxLen];
  logic [CW-1:0] seen_q;
  logic shift;
  assign shift = cmd_i.load_in && in_cmd_i == CmdBase;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MaxLen; i++) win_q[i] <= '0;
      seen_q <= '0;
    end else begin
      if (shift) begin
        for (int i = 0; i < MaxLen - 1; i++) win_q[i] <= win_q[i+1];
        win_q[MaxLen-1] <= in_base_i;
        if (32'(seen_q) < MaxLen) seen_q <= seen_q + CW'(1);
      end
      if (cmd_i.finish) seen_q <= '0;
    end
  end

  // Column counter and the two memory reads (forward, reverse).
  logic [CW-1:0] j_q;
  logic [2:0] bj;
  logic [IW-1:0] widx, fcol, rcol;
  logic [AW-1:0] wr_a;
  assign widx = IW'(32'(MaxLen) - 32'(len) + 32'(j_q));
  assign bj = win_q[widx];
  assign fcol = IW'(j_q);
  assign rcol = IW'(len - CW'(1) - j_q);
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) j_q <= '0;
    else if (cmd_i.clr_acc) j_q <= '0;
    else if (cmd_i.acc_step) j_q <= j_q + CW'(1);
  end

  // Two-port weight memory (dual read, registered).
  logic signed [WBits-1:0] mem [MaxLen*4];
  logic signed [WBits-1:0] rf_q, rr_q;
  logic vld_q;
  assign wr_a = {IW'(col_q), row_q};
  always_ff @(posedge clk_i) begin
    if (cmd_i.acc_step == 1'b0 && cmd_q == CmdLoad && cmd_i.fold == 1'b0
        && cmd_i.clr_acc && 32'(col_q) < MaxLen)
      mem[wr_a] <= wsat;
    rf_q <= mem[{fcol, bj[1:0]}];
    rr_q <= mem[{rcol, ~bj[1:0]}];
  end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vld_q <= 1'b0;
    else vld_q <= cmd_i.acc_step && !bj[2];
  end

  // Accumulators, one stage behind the reads.
  logic signed [ACCW-1:0] fs_q, rs_q;
  always_ff @(posedge clk_i) begin
    if (cmd_i.clr_acc) begin
      fs_q <= '0; rs_q <= '0;
    end else if (vld_q) begin
      fs_q <= fs_q + ACCW'(rf_q);
      rs_q <= rs_q + ACCW'(rr_q);
    end
  end

  function automatic logic signed [SBits-1:0] sat_s(input logic signed [ACCW-1:0] v);
    if (v > ACCW'(SMax)) return SMax;
    if (v < ACCW'(SMin)) return SMin;
    return SBits'(v);
  endfunction

  // Best score and sequence bookkeeping.
  logic signed [SBits-1:0] best_q, fsat, rsat, m1;
  logic havew_q;
  logic [31:0] seq_q;
  assign fsat = sat_s(fs_q);
  assign rsat = sat_s(rs_q);
  assign m1 = (fsat > best_q) ? fsat : best_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      best_q <= SMin; havew_q <= 1'b0; seq_q <= '0;
    end else if (cmd_i.finish) begin
      best_q <= SMin; havew_q <= 1'b0; seq_q <= seq_q + 32'd1;
    end else if (cmd_i.fold) begin
      best_q <= (rsat > m1) ? rsat : m1;
      havew_q <= 1'b1;
    end
  end

  logic hit;
  assign hit = havew_q && (32'(best_q) >= 32'(thr_q));
  assign res_index_o = seq_q;
  assign res_hit_o = hit;
  assign res_score_o = hit ? 24'(best_q) : '0;

  assign sts_o.is_base = cmd_q == CmdBase;
  assign sts_o.is_last = last_q;
  assign sts_o.have_win = seen_q >= len;
  assign sts_o.col_done = j_q == len;
endmodule
`default_nettype wire

// ===== src/pms_ctrl.sv =====
// ----------------------------------------------------------------------------
// pms_ctrl
// Sequencer: capture, column sweep, fold, and result hand-off.
// ----------------------------------------------------------------------------
`default_nettype none
`include "pwm_motif_scan_both_strands_unit_macros.svh"
module pms_ctrl (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output logic in_ready_o,
  output logic out_valid_o,
  input  wire logic out_ready_i,
  output pms_pkg::pms_cmd_t cmd_o,
  input  wire pms_pkg::pms_sts_t sts_i
);
  import pms_pkg::*;
  localparam logic [2:0] SIdle = 3'd0, SDec = 3'd1, SSum = 3'd2,
                         SDrain = 3'd3, SFold = 3'd4, SOut = 3'd5;
  logic [2:0] st_q, st_d;

  always_comb begin
    st_d = st_q;
    cmd_o = '0;
    in_ready_o = 1'b0;
    out_valid_o = 1'b0;
    case (st_q)
      SIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load_in = 1'b1;
          st_d = SDec;
        end
      end
      SDec: begin
        cmd_o.clr_acc = 1'b1;
        if (!sts_i.is_base) st_d = SIdle;
        else if (sts_i.have_win) st_d = SSum;
        else if (sts_i.is_last) st_d = SOut;
        else st_d = SIdle;
      end
      SSum: begin
        if (sts_i.col_done) st_d = SDrain;
        else cmd_o.acc_step = 1'b1;
      end
      SDrain: st_d = SFold;
      SFold: begin
        cmd_o.fold = 1'b1;
        st_d = sts_i.is_last ? SOut : SIdle;
      end
      SOut: begin
        out_valid_o = 1'b1;
        if (out_ready_i) begin
          cmd_o.finish = 1'b1;
          st_d = SIdle;
        end
      end
      default: st_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) st_q <= SIdle;
    else st_q <= st_d;
  end

  `PMS_ASSERT(a_no_both, clk_i, rst_ni, !(in_ready_o && out_valid_o), "ready during result")
  `PMS_ASSERT(a_fold_once, clk_i, rst_ni, cmd_o.fold |=> !cmd_o.fold, "double fold")
  `PMS_ASSERT(a_out_hold, clk_i, rst_ni, (out_valid_o && !out_ready_i) |=> out_valid_o, "result dropped")
endmodule
`default_nettype wire
